// ===== src/tsfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture swizzle format converter package
// Shared types, register map codes, pixel format codes and swizzle constants.
// ----------------------------------------------------------------------------
package tsfc_pkg;

    // Default log2 of the largest image side in pixels.
    localparam int MAX_SIDE_LOG2_DEF = 10;

    // Byte-space masked-add steps and masks for the Z-order codes.
    localparam logic [31:0] ROW_STEP_BYTES = 32'hAAAA_AAAC;
    localparam logic [31:0] ROW_BITS_BYTES = 32'h5555_5555;
    localparam logic [31:0] COL_STEP_BYTES = 32'h5555_5558;
    localparam logic [31:0] COL_BITS_BYTES = 32'hAAAA_AAAA;

    // Texel conversion constants.
    localparam logic [31:0] NIBBLE_HI = 32'h0000_00F0;
    localparam logic [15:0] WHITE_ONE = 16'h0FFF;

    // Configuration port geometry.
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes (byte address divided by four).
    typedef enum logic [1:0] {
        REG_PIXEL_FORMAT = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } t_reg_index;

    // Source pixel formats.
    typedef enum logic [1:0] {
        FMT_ALPHA8 = 2'd0,
        FMT_RGB16  = 2'd1,
        FMT_RGB32  = 2'd2,
        FMT_ARGB32 = 2'd3
    } t_pixel_format;

    // Configuration register contents.
    typedef struct packed {
        t_pixel_format pixel_format;
        logic [10:0]   image_width;
        logic [10:0]   image_height;
    } t_cfg;

    // Input item: one horizontal pixel pair.
    typedef struct packed {
        logic [31:0] first_pixel;
        logic [31:0] second_pixel;
    } t_in_item;

    // Output item: one swizzled texture word.
    typedef struct packed {
        logic [19:0] word_index;
        logic [31:0] word_data;
        logic        row_done;
        logic        image_done;
    } t_out_item;

    // Placement of the current word, from the address generator.
    typedef struct packed {
        logic [19:0] word_index;
        logic        row_done;
        logic        image_done;
        logic        lone;
    } t_addr_info;

endpackage

// ===== src/tsfc_texel_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texel conversion lane
// Converts one source pixel into a 16-bit texel by the configured format.
// ----------------------------------------------------------------------------
module tsfc_texel_lane
    import tsfc_pkg::*;
(
    input  t_pixel_format i_pixel_format,
    input  logic [31:0]   i_pixel,
    output logic [15:0]   o_texel
);

    // Pick channel bits according to the source format.
    always_comb begin
        case (i_pixel_format)
            FMT_ALPHA8: begin
                o_texel = 16'((i_pixel & NIBBLE_HI) << 8) | WHITE_ONE;
            end
            FMT_RGB16: begin
                o_texel = i_pixel[15:0];
            end
            FMT_RGB32: begin
                o_texel = {i_pixel[23:19], i_pixel[15:10], i_pixel[7:3]};
            end
            FMT_ARGB32: begin
                o_texel = {i_pixel[31:28], i_pixel[23:20], i_pixel[15:12], i_pixel[7:4]};
            end
            default: begin
                o_texel = 16'h0000;
            end
        endcase
    end

endmodule

// ===== src/tsfc_addr_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Z-order address generator
// Tracks row and pair position and builds the interleaved word index with
// masked-add counters.
// ----------------------------------------------------------------------------
module tsfc_addr_gen
    import tsfc_pkg::*;
#(
    parameter int MAX_SIDE_LOG2 = MAX_SIDE_LOG2_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_advance,
    output t_addr_info o_info
);

    localparam int CW = 2 * MAX_SIDE_LOG2;
    localparam int NW = MAX_SIDE_LOG2;
    localparam logic [31:0] COL_STEP = COL_STEP_BYTES >> 2;
    localparam logic [31:0] COL_MASK = COL_BITS_BYTES >> 2;
    localparam logic [31:0] ROW_STEP = ROW_STEP_BYTES >> 2;
    localparam logic [31:0] ROW_MASK = ROW_BITS_BYTES >> 2;
    localparam logic [31:0] SIDE_MAX = 32'(1) << MAX_SIDE_LOG2;

    logic [CW-1:0] r_col_code,   n_col_code;
    logic [CW-1:0] r_row_code,   n_row_code;
    logic [NW-1:0] r_pair_count, n_pair_count;
    logic [NW-1:0] r_row_count,  n_row_count;

    logic [31:0] width32;
    logic [31:0] height32;
    logic [NW:0] width_c;
    logic [NW:0] height_c;
    logic [NW:0] pairs;
    logic        last_in_row;
    logic        last_row;
    logic [31:0] index32;

    // Clamp the image sides to the supported range.
    always_comb begin
        width32  = 32'(i_cfg.image_width);
        height32 = 32'(i_cfg.image_height);
        if (width32 == 32'd0) begin
            width_c = (NW+1)'(1);
        end else if (width32 > SIDE_MAX) begin
            width_c = (NW+1)'(SIDE_MAX);
        end else begin
            width_c = (NW+1)'(width32);
        end
        if (height32 == 32'd0) begin
            height_c = (NW+1)'(1);
        end else if (height32 > SIDE_MAX) begin
            height_c = (NW+1)'(SIDE_MAX);
        end else begin
            height_c = (NW+1)'(height32);
        end
    end

    // Row and image end detection for the current word.
    always_comb begin
        pairs       = (width_c + (NW+1)'(1)) >> 1;
        last_in_row = ((NW+1)'(r_pair_count) + (NW+1)'(1)) >= pairs;
        last_row    = ((NW+1)'(r_row_count) + (NW+1)'(1)) >= height_c;
        index32     = 32'(r_row_code | r_col_code);

        o_info.word_index = index32[19:0];
        o_info.row_done   = last_in_row;
        o_info.image_done = last_in_row & last_row;
        o_info.lone       = last_in_row & width_c[0];
    end

    // Counter and code updates for the next word.
    always_comb begin
        n_col_code   = r_col_code;
        n_row_code   = r_row_code;
        n_pair_count = r_pair_count;
        n_row_count  = r_row_count;
        if (i_advance) begin
            if (!last_in_row) begin
                n_pair_count = r_pair_count + NW'(1);
                n_col_code   = (r_col_code + COL_STEP[CW-1:0]) & COL_MASK[CW-1:0];
            end else if (!last_row) begin
                n_pair_count = '0;
                n_col_code   = '0;
                n_row_count  = r_row_count + NW'(1);
                n_row_code   = (r_row_code + ROW_STEP[CW-1:0]) & ROW_MASK[CW-1:0];
            end else begin
                n_pair_count = '0;
                n_col_code   = '0;
                n_row_count  = '0;
                n_row_code   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_code   <= '0;
            r_row_code   <= '0;
            r_pair_count <= '0;
            r_row_count  <= '0;
        end else begin
            r_col_code   <= n_col_code;
            r_row_code   <= n_row_code;
            r_pair_count <= n_pair_count;
            r_row_count  <= n_row_count;
        end
    end

endmodule

// ===== src/tsfc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding pixel format and image dimensions.
// ----------------------------------------------------------------------------
module tsfc_cfg_regs
    import tsfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg, n_cfg;
    t_reg_index reg_sel;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_index'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign o_cfg   = r_cfg;

    // Register write decode; addresses past the last register are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_sel)
                REG_PIXEL_FORMAT: n_cfg.pixel_format = t_pixel_format'(pwdata[1:0]);
                REG_IMAGE_WIDTH:  n_cfg.image_width  = pwdata[10:0];
                REG_IMAGE_HEIGHT: n_cfg.image_height = pwdata[10:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        case (reg_sel)
            REG_PIXEL_FORMAT: prdata = APB_DW'(r_cfg.pixel_format);
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_cfg.image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_cfg.image_height);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_format <= FMT_ALPHA8;
            r_cfg.image_width  <= 11'd1;
            r_cfg.image_height <= 11'd1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== src/texture_swizzle_format_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture swizzle format converter
// Converts horizontal pixel pairs to packed 16-bit texels and tags each
// word with its Z-order (Morton) word index.
//
//   Channel  Direction  Handshake                  Payload
//   input    in         i_in_valid / o_in_stall    i_in_item  (pixel pair)
//   output   out        o_out_valid / i_out_stall  o_out_item (texture word)
//   config   in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item per cycle unless the output stalls: two conversion lanes and the
// address generator finish in the cycle of acceptance, and the output
// register holds the word; it is at the output the cycle after acceptance.
// Reset is synchronous and active low; it clears counters and output valid.
// o_in_stall is high only while the output register is full and stalled.
// ----------------------------------------------------------------------------
module texture_swizzle_format_converter
    import tsfc_pkg::*;
#(
    parameter int MAX_SIDE_LOG2 = MAX_SIDE_LOG2_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg       cfg;
    t_addr_info info;
    logic [15:0] texel0;
    logic [15:0] texel1;
    logic        in_accept;
    logic [31:0] merged_data;

    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_item,  n_out_item;

    // Configuration registers.
    tsfc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Two conversion lanes, one per pixel of the pair.
    tsfc_texel_lane u_lane0 (
        .i_pixel_format (cfg.pixel_format),
        .i_pixel        (i_in_item.first_pixel),
        .o_texel        (texel0)
    );

    tsfc_texel_lane u_lane1 (
        .i_pixel_format (cfg.pixel_format),
        .i_pixel        (i_in_item.second_pixel),
        .o_texel        (texel1)
    );

    // Word placement.
    tsfc_addr_gen #(
        .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
    ) u_addr_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (in_accept),
        .o_info    (info)
    );

    // Handshake: accept whenever the output register is free or draining.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    // Merge the lanes; a trailing odd pixel leaves the high half empty.
    assign merged_data = info.lone ? {16'h0000, texel0} : {texel1, texel0};

    // Output register next state.
    always_comb begin
        n_out_valid = r_out_valid & i_out_stall;
        n_out_item  = r_out_item;
        if (in_accept) begin
            n_out_valid           = 1'b1;
            n_out_item.word_index = info.word_index;
            n_out_item.word_data  = merged_data;
            n_out_item.row_done   = info.row_done;
            n_out_item.image_done = info.image_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the texture swizzle format converter
// Streams pixel pairs through the block under several register settings and
// checks every texture word (Z-order index, packed texels, row and image end
// flags) against a cycle-free model of the swizzle kept inside the bench.
// Both handshakes idle at random, and the output is held off once for a long
// stretch so that the block has to stall its input.
// ----------------------------------------------------------------------------
module tb;
    import tsfc_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int TARGET_PAIRS = 1850;
    localparam int MAX_SIDE     = 1 << MAX_SIDE_LOG2_DEF;

    // Clock, reset and block ports.
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in_item = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_item;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Register copies as the block should hold them.
    t_pixel_format cfg_format = FMT_ALPHA8;
    logic [10:0]   cfg_width = 11'd1;
    logic [10:0]   cfg_height = 11'd1;

    // Swizzle counters of the model.
    logic [19:0] column_code = '0;
    logic [19:0] row_code = '0;
    logic [9:0]  pair_count = '0;
    logic [10:0] row_count = '0;

    t_in_item  pairs_to_send[$];
    t_out_item words_due[$];
    bit        pair_taken = 1'b0;
    int        pairs_queued = 0;
    int        words_checked = 0;
    int        mismatch_count = 0;
    int        cycle_count = 0;

    texture_swizzle_format_converter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // A side of 0 counts as 1, and anything above the largest side as the largest.
    function automatic int unsigned side_in_use(input logic [10:0] v);
        if (v == 11'd0) begin
            return 1;
        end
        return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
    endfunction

    // One source pixel to a 16-bit texel under the current format.
    function automatic logic [15:0] texel_of(input logic [31:0] p);
        case (cfg_format)
            FMT_ALPHA8: begin
                return {p[7:4], WHITE_ONE[11:0]};
            end
            FMT_RGB16: begin
                return p[15:0];
            end
            FMT_RGB32: begin
                return {p[23:19], p[15:10], p[7:3]};
            end
            default: begin
                return {p[31:28], p[23:20], p[15:12], p[7:4]};
            end
        endcase
    endfunction

    // Texture word produced by one pixel pair; advances the swizzle counters.
    function automatic t_out_item next_texture_word(input t_in_item pair);
        int unsigned w;
        int unsigned h;
        int unsigned pairs_per_row;
        logic        last_col;
        logic        last_row;
        t_out_item   word;
        w = side_in_use(cfg_width);
        h = side_in_use(cfg_height);
        pairs_per_row = (w + 1) >> 1;
        last_col = (int'(pair_count) + 1) >= pairs_per_row;
        last_row = (int'(row_count) + 1) >= h;
        word.word_index = row_code | column_code;
        if (last_col && w[0]) begin
            word.word_data = {16'h0000, texel_of(pair.first_pixel)};
        end else begin
            word.word_data = {texel_of(pair.second_pixel), texel_of(pair.first_pixel)};
        end
        word.row_done = last_col;
        word.image_done = last_col && last_row;
        if (!last_col) begin
            pair_count = pair_count + 1'b1;
            column_code = (column_code + COL_STEP_BYTES[21:2]) & COL_BITS_BYTES[21:2];
        end else if (!last_row) begin
            pair_count = '0;
            column_code = '0;
            row_count = row_count + 1'b1;
            row_code = (row_code + ROW_STEP_BYTES[21:2]) & ROW_BITS_BYTES[21:2];
        end else begin
            pair_count = '0;
            column_code = '0;
            row_count = '0;
            row_code = '0;
        end
        return word;
    endfunction

    // Input side: every accepted pair yields one expected word.
    always @(posedge i_clk) begin
        pair_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (pair_taken) begin
            words_due.push_back(next_texture_word(i_in_item));
        end
    end

    // Sender: bursts of items with random gaps, holding a stalled item steady.
    int burst_left = 1;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (pair_taken) begin
                void'(pairs_to_send.pop_front());
            end
            if (!i_in_valid || pair_taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pairs_to_send.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_item <= pairs_to_send[0];
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern that changes now and then, plus one long hold-off
    // while the sender keeps offering items.
    int stall_mode = 0;
    int mode_left = 0;
    int pattern_step = 0;
    int hold_left = 0;
    bit hold_used = 1'b0;
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_used && words_checked >= 200 && i_in_valid) begin
            hold_used = 1'b1;
            hold_left = 120;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left <= 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            pattern_step++;
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= 1'($urandom_range(0, 1));
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ((pattern_step % 5) < 2);
            endcase
        end
    end

    task automatic note_mismatch(input string what, input t_out_item want,
                                 input t_out_item got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch (%s): expected index %05h data %08h row %0b image %0b",
                     what, want.word_index, want.word_data, want.row_done,
                     want.image_done);
            $display("                got index %05h data %08h row %0b image %0b",
                     got.word_index, got.word_data, got.row_done, got.image_done);
        end
    endtask

    // Output side: compare each accepted word with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_checked++;
            if (words_due.size() == 0) begin
                note_mismatch("unexpected word", '0, o_out_item);
            end else begin
                want = words_due.pop_front();
                if (o_out_item.word_index !== want.word_index
                        || o_out_item.word_data !== want.word_data
                        || o_out_item.row_done !== want.row_done
                        || o_out_item.image_done !== want.image_done) begin
                    note_mismatch("wrong word", want, o_out_item);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(input t_reg_index idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_PIXEL_FORMAT: cfg_format = t_pixel_format'(value[1:0]);
            REG_IMAGE_WIDTH:  cfg_width = value[10:0];
            default:          cfg_height = value[10:0];
        endcase
    endtask

    // Writes all three registers; the unused upper bits sometimes carry junk.
    task automatic set_config(input t_pixel_format fmt, input int w, input int h);
        logic [31:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? $urandom() : 32'h0;
        write_reg(REG_PIXEL_FORMAT, {junk[31:2], fmt});
        write_reg(REG_IMAGE_WIDTH, {junk[31:11], 11'(w)});
        write_reg(REG_IMAGE_HEIGHT, {junk[31:11], 11'(h)});
    endtask

    task automatic queue_pair(input logic [31:0] a, input logic [31:0] b);
        t_in_item pair;
        pair.first_pixel = a;
        pair.second_pixel = b;
        pairs_to_send.push_back(pair);
        pairs_queued++;
    endtask

    // Wait until every item is sent and every word has come back.
    task automatic drain();
        while (pairs_to_send.size() != 0 || words_due.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    initial begin
        t_pixel_format fmt;
        int            w;
        int            h;
        int            pick;
        int            image_words;
        int            n;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: single-pixel alpha images, every word ends the image.
        queue_pair(32'h0000_0000, 32'hFFFF_FFFF);
        queue_pair(32'hFFFF_FFFF, 32'h0000_0000);
        drain();

        // Odd width: the last word of each row carries one texel.
        set_config(FMT_RGB16, 3, 2);
        queue_pair(32'h0000_FFFF, 32'hFFFF_0000);
        queue_pair(32'hA5A5_A5A5, 32'h5A5A_5A5A);
        queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_pair(32'h1234_8001, 32'hFFFF_FFFF);
        drain();

        // Zero sides count as one.
        set_config(FMT_RGB32, 0, 0);
        queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_pair(32'h00F8_FCF8, 32'h0007_0307);
        drain();

        // Even width, several rows.
        set_config(FMT_ARGB32, 4, 3);
        queue_pair(32'hFFFF_FFFF, 32'h0000_0000);
        queue_pair(32'hF0F0_F0F0, 32'h0F0F_0F0F);
        queue_pair(32'h8040_2010, 32'h0000_0000);
        queue_pair(32'h0000_0000, 32'hFFFF_FFFF);
        queue_pair(32'hF000_0000, 32'h0000_00F0);
        queue_pair(32'h00F0_0000, 32'h0000_F000);
        drain();

        // Stop mid-row, then shrink the image under the running counters.
        set_config(FMT_ALPHA8, 9, 3);
        queue_pair(32'h0000_00F0, 32'hFFFF_FF0F);
        queue_pair(32'h0000_0080, 32'h0000_0010);
        queue_pair(32'hFFFF_FFFF, 32'h0000_0000);
        drain();
        set_config(FMT_ALPHA8, 2, 1);
        queue_pair(32'h0000_0070, 32'h0000_00A0);
        queue_pair(32'h0000_00F0, 32'h0000_0000);
        drain();

        // Widest row, width given above the largest side.
        set_config(FMT_ARGB32, 2047, 2);
        repeat (515) queue_pair($urandom(), $urandom());
        drain();

        // Random settings, mostly small images.
        while (pairs_queued < TARGET_PAIRS) begin
            fmt = t_pixel_format'($urandom_range(0, 3));
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                w = $urandom_range(1, 12);
            end else if (pick == 8) begin
                w = $urandom_range(13, 64);
            end else begin
                case ($urandom_range(0, 3))
                    0: w = 0;
                    1: w = MAX_SIDE;
                    2: w = MAX_SIDE + 1;
                    default: w = 2047;
                endcase
            end
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                h = $urandom_range(1, 6);
            end else begin
                case ($urandom_range(0, 3))
                    0: h = 0;
                    1: h = MAX_SIDE;
                    2: h = MAX_SIDE + 1;
                    default: h = 2047;
                endcase
            end
            image_words = ((side_in_use(11'(w)) + 1) >> 1) * side_in_use(11'(h));
            if (image_words <= 150 && $urandom_range(0, 2) != 0) begin
                n = image_words * $urandom_range(1, 2);
            end else begin
                n = $urandom_range(1, 60);
            end
            set_config(fmt, w, h);
            repeat (n) queue_pair($urandom(), $urandom());
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && words_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
